// File: rtl/huffq_pkg.sv
// Shared types, codes and node ordering function for the Huffman merge queue.
`timescale 1ns / 1ps
`default_nettype none
package huffq_pkg;

  localparam int WEIGHT_W = 32;
  localparam int ID_W     = 9;
  localparam int SYM_W    = 8;
  localparam int STATUS_W = 3;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [ID_W-1:0]     id;
  } node_t;

  typedef struct packed {
    logic  ins_en;
    logic  drop_en;
    node_t new_node;
  } cell_ctl_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_INSERTED  = 3'd0,
    STATUS_MERGED    = 3'd1,
    STATUS_ROOT      = 3'd2,
    STATUS_FULL      = 3'd3,
    STATUS_EMPTY     = 3'd4,
    STATUS_SATURATED = 3'd5
  } status_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_MERGE  = 1'b1
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } fsm_t;

  localparam logic [ID_W-1:0] ID_FIRST_INTERNAL = 9'd256;

  function automatic logic goes_before(input node_t a, input node_t e);
    logic r;
    if (a.weight < e.weight) begin
      r = 1'b1;
    end else if (a.weight > e.weight) begin
      r = 1'b0;
    end else if (e.id[ID_W-1]) begin
      r = 1'b0;
    end else if (a.id[ID_W-1]) begin
      r = 1'b1;
    end else begin
      r = (a.id < e.id);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/huffman_tree_merge_queue_unit.sv
// Top level of the Huffman merge queue: cell chain, count, id counter and request control.
// Insert: result strobe in the cycle after the request; busy stays low, next request the next cycle.
// Merge of two nodes: drop two heads from ST_IDLE, place the sum in ST_MERGE;
//   busy is high for one cycle and the result strobes from the done register set in ST_MERGE.
// Other merges and a rejected insert answer in the cycle after the request.
// Reset (rst, synchronous) empties the queue and sets the internal id to 256.
`timescale 1ns / 1ps
`default_nettype none
module huffman_tree_merge_queue_unit
  import huffq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 256
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                operation,
  input  wire logic [SYM_W-1:0]    symbol,
  input  wire logic [WEIGHT_W-1:0] weight,
  output logic                     done,
  output logic [STATUS_W-1:0]      status,
  output logic [ID_W-1:0]          left_node,
  output logic [ID_W-1:0]          right_node,
  output logic [ID_W-1:0]          new_node,
  output logic [WEIGHT_W-1:0]      node_weight
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  fsm_t              state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [ID_W-1:0]   next_id;
  logic [WEIGHT_W-1:0] sum_q;
  logic              ovf_q;
  logic [ID_W-1:0]   ida_q, idb_q;
  logic              capture;
  logic              done_next;
  status_t           status_q, status_next;
  logic [ID_W-1:0]   left_next, right_next, new_next;
  logic [WEIGHT_W-1:0] weight_next;
  logic [WEIGHT_W:0] sum_wide;
  cell_ctl_t         ctl;
  node_t             cells [QUEUE_DEPTH];
  logic              ins   [QUEUE_DEPTH];
  logic              full;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign sum_wide = {1'b0, cells[0].weight} + {1'b0, cells[1].weight};

  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic  occ;
      logic  l_ins;
      node_t l_node;
      node_t f_node;
      assign occ = (CNT_W'(i) < count);
      if (i == 0) begin : g_first
        assign l_ins  = 1'b0;
        assign l_node = '0;
      end else begin : g_rest
        assign l_ins  = ins[i-1];
        assign l_node = cells[i-1];
      end
      if (i + 2 < QUEUE_DEPTH) begin : g_far
        assign f_node = cells[i+2];
      end else begin : g_tail
        assign f_node = cells[i];
      end
      huffq_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .occupied  (occ),
        .left_ins  (l_ins),
        .left_node (l_node),
        .far_node  (f_node),
        .node      (cells[i]),
        .ins       (ins[i])
      );
    end
  endgenerate

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start && (operation == OP_MERGE) && (count > CNT_W'(1))) begin
          state_next = ST_MERGE;
        end
      end
      ST_MERGE: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy         = (state == ST_MERGE);
    ctl.ins_en   = 1'b0;
    ctl.drop_en  = 1'b0;
    ctl.new_node = (state == ST_MERGE) ? node_t'{weight: sum_q, id: next_id}
                                       : node_t'{weight: weight, id: {1'b0, symbol}};
    count_next   = count;
    capture      = 1'b0;
    done_next    = 1'b0;
    status_next  = STATUS_INSERTED;
    left_next    = '0;
    right_next   = '0;
    new_next     = '0;
    weight_next  = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          done_next = 1'b1;
          if (operation == OP_INSERT) begin
            if (full) begin
              status_next = STATUS_FULL;
            end else begin
              ctl.ins_en  = 1'b1;
              count_next  = count + CNT_W'(1);
              status_next = STATUS_INSERTED;
              new_next    = {1'b0, symbol};
              weight_next = weight;
            end
          end else if (count == '0) begin
            status_next = STATUS_EMPTY;
          end else if (count == CNT_W'(1)) begin
            status_next = STATUS_ROOT;
            new_next    = cells[0].id;
            weight_next = cells[0].weight;
          end else begin
            ctl.drop_en = 1'b1;
            count_next  = count - CNT_W'(2);
            capture     = 1'b1;
            done_next   = 1'b0;
          end
        end
      end
      ST_MERGE: begin
        ctl.ins_en  = 1'b1;
        count_next  = count + CNT_W'(1);
        done_next   = 1'b1;
        status_next = ovf_q ? STATUS_SATURATED : STATUS_MERGED;
        left_next   = ida_q;
        right_next  = idb_q;
        new_next    = next_id;
        weight_next = sum_q;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      next_id <= ID_FIRST_INTERNAL;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
      if (state == ST_MERGE) begin
        next_id <= {1'b1, next_id[ID_W-2:0] + (ID_W-1)'(1)};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      sum_q <= sum_wide[WEIGHT_W] ? '1 : sum_wide[WEIGHT_W-1:0];
      ovf_q <= sum_wide[WEIGHT_W];
      ida_q <= cells[0].id;
      idb_q <= cells[1].id;
    end
    status_q    <= status_next;
    left_node   <= left_next;
    right_node  <= right_next;
    new_node    <= new_next;
    node_weight <= weight_next;
  end

  assign status = status_q;

endmodule
`default_nettype wire

// File: rtl/huffq_cell.sv
// One cell of the sorted queue: holds a node, shifts right on insert, left by two on drop.
`timescale 1ns / 1ps
`default_nettype none
module huffq_cell
  import huffq_pkg::*;
(
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire logic      occupied,
  input  wire logic      left_ins,
  input  wire node_t     left_node,
  input  wire node_t     far_node,
  output node_t          node,
  output logic           ins
);

  assign ins = !occupied || goes_before(ctl.new_node, node);

  always_ff @(posedge clk) begin
    if (ctl.drop_en) begin
      node <= far_node;
    end else if (ctl.ins_en) begin
      if (left_ins) begin
        node <= left_node;
      end else if (ins) begin
        node <= ctl.new_node;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/huffq_checker.sv
// Port-level checker for the Huffman merge queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module huffq_checker
  import huffq_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                operation,
  input wire logic                done,
  input wire logic [STATUS_W-1:0] status,
  input wire logic [ID_W-1:0]     left_node,
  input wire logic [ID_W-1:0]     right_node
);

  a_insert_answers: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (operation == OP_INSERT) |=> done)
    else $error("insert request not answered in one cycle");

  a_merge_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (operation == OP_MERGE) |=> done || busy)
    else $error("merge request neither answered nor in progress");

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy && done &&
      (status == STATUS_MERGED || status == STATUS_SATURATED))
    else $error("merge phase did not end with a merge result");

  a_leaf_no_children: assert property (@(posedge clk) disable iff (rst)
    done && (status == STATUS_INSERTED) |-> left_node == '0 && right_node == '0)
    else $error("insert result carries child ids");

endmodule

bind huffman_tree_merge_queue_unit huffq_checker u_huffq_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .operation  (operation),
  .done       (done),
  .status     (status),
  .left_node  (left_node),
  .right_node (right_node)
);
`default_nettype wire
